/* rtl/light_triggered_servo_pwm_assert.svh */
// assertion macros for the servo pwm block
`ifndef LIGHT_TRIGGERED_SERVO_PWM_ASSERT_SVH
`define LIGHT_TRIGGERED_SERVO_PWM_ASSERT_SVH

// same-cycle implication
`define LTSP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo pwm check failed");

// next-cycle implication
`define LTSP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo pwm check failed");

`endif

/* rtl/ltsp_pkg.sv */
package ltsp_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] REG_PERIOD   = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_TICK     = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_HIGH_THR = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_LOW_THR  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_HOLDOFF  = 3'd4;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_KEY  = 2'd1;
  localparam logic [1:0] OP_ADC  = 2'd2;

  localparam logic [3:0] KEY_ANGLE_45  = 4'hE;
  localparam logic [3:0] KEY_ANGLE_90  = 4'hD;
  localparam logic [3:0] KEY_ANGLE_120 = 4'hB;

  localparam logic [6:0] ANGLE_0   = 7'd0;
  localparam logic [6:0] ANGLE_45  = 7'd45;
  localparam logic [6:0] ANGLE_90  = 7'd90;
  localparam logic [6:0] ANGLE_120 = 7'd120;

  localparam logic [15:0] PERIOD_RESET   = 16'd20000;
  localparam logic [9:0]  TICK_RESET     = 10'd100;
  localparam logic [9:0]  HIGH_THR_RESET = 10'd750;
  localparam logic [9:0]  LOW_THR_RESET  = 10'd600;
  localparam logic [15:0] HOLDOFF_RESET  = 16'd10000;

  localparam logic [11:0] DUTY_0   = 12'(500 + (0 * 200) / 18);
  localparam logic [11:0] DUTY_45  = 12'(500 + (45 * 200) / 18);
  localparam logic [11:0] DUTY_90  = 12'(500 + (90 * 200) / 18);
  localparam logic [11:0] DUTY_120 = 12'(500 + (120 * 200) / 18);
  localparam logic [11:0] DUTY_RESET = 12'd1500;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] key_bits;
    logic [9:0] adc_value;
  } item_t;

  typedef struct packed {
    logic [15:0] period_us;
    logic [9:0]  tick_us;
    logic [9:0]  high_threshold;
    logic [9:0]  low_threshold;
    logic [15:0] holdoff_ticks;
  } cfg_t;

  typedef struct packed {
    logic        servo_level;
    logic [11:0] duty_us;
    logic        is_armed;
  } result_t;

  function automatic logic [11:0] pulse_for(input logic [6:0] angle);
    logic [11:0] duty;
    case (angle)
      ANGLE_45:  duty = DUTY_45;
      ANGLE_90:  duty = DUTY_90;
      ANGLE_120: duty = DUTY_120;
      default:   duty = DUTY_0;
    endcase
    return duty;
  endfunction

endpackage

/* rtl/light_triggered_servo_pwm.sv */
// channel  | direction | handshake                    | payload
// item     | in        | item_valid / item_ready      | op, key_bits, adc_value
// result   | out       | result_valid / result_ready  | servo_level, duty_us, is_armed
// cfg      | in        | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// one item per cycle sustained while results are accepted; an item beat passes
// through the input register, then the state update into the result register
// rst is synchronous: config and state registers go to their power-on values, both stages empty
// a result stall backs up through the input register; cfg_ready is always high
`include "light_triggered_servo_pwm_assert.svh"

module light_triggered_servo_pwm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [1:0]                     op,
  input  logic [3:0]                     key_bits,
  input  logic [9:0]                     adc_value,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           servo_level,
  output logic [11:0]                    duty_us,
  output logic                           is_armed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ltsp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ltsp_pkg::CfgDataW-1:0]  cfg_data
);

  ltsp_pkg::cfg_t    cfg;
  ltsp_pkg::item_t   item;
  ltsp_pkg::result_t result, result_next;
  logic              item_full;
  logic              advance;
  logic              armed;
  logic              holdoff_busy;

  assign cfg_ready  = 1'b1;
  assign advance    = item_full && (!result_valid || result_ready);
  assign item_ready = !item_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_us      <= ltsp_pkg::PERIOD_RESET;
      cfg.tick_us        <= ltsp_pkg::TICK_RESET;
      cfg.high_threshold <= ltsp_pkg::HIGH_THR_RESET;
      cfg.low_threshold  <= ltsp_pkg::LOW_THR_RESET;
      cfg.holdoff_ticks  <= ltsp_pkg::HOLDOFF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ltsp_pkg::REG_PERIOD:   cfg.period_us      <= cfg_data;
        ltsp_pkg::REG_TICK:     cfg.tick_us        <= cfg_data[9:0];
        ltsp_pkg::REG_HIGH_THR: cfg.high_threshold <= cfg_data[9:0];
        ltsp_pkg::REG_LOW_THR:  cfg.low_threshold  <= cfg_data[9:0];
        ltsp_pkg::REG_HOLDOFF:  cfg.holdoff_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_ready) begin
      item_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item.op        <= op;
      item.key_bits  <= key_bits;
      item.adc_value <= adc_value;
    end
  end

  ltsp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item),
    .cfg          (cfg),
    .result_next  (result_next),
    .armed        (armed),
    .holdoff_busy (holdoff_busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign servo_level = result.servo_level;
  assign duty_us     = result.duty_us;
  assign is_armed    = result.is_armed;

  `LTSP_ASSERT_IMP(a_duty_legal, clk, rst, result_valid, (duty_us == ltsp_pkg::DUTY_0) || (duty_us == ltsp_pkg::DUTY_45) || (duty_us == ltsp_pkg::DUTY_90) || (duty_us == ltsp_pkg::DUTY_120) || (duty_us == ltsp_pkg::DUTY_RESET))
  `LTSP_ASSERT_NXT(a_armed_sticks, clk, rst, armed, armed)
  `LTSP_ASSERT_NXT(a_holdoff_freezes_duty, clk, rst, advance && holdoff_busy && (item.op == ltsp_pkg::OP_ADC), result.duty_us == $past(result_next.duty_us) && result_next.duty_us == result.duty_us)
  `LTSP_ASSERT_IMP(a_stall_blocks, clk, rst, item_full && result_valid && !result_ready, !item_ready)

endmodule

/* rtl/ltsp_core.sv */
module ltsp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  ltsp_pkg::item_t   item,
  input  ltsp_pkg::cfg_t    cfg,
  output ltsp_pkg::result_t result_next,
  output logic              armed,
  output logic              holdoff_busy
);

  logic [11:0] duty_time, duty_time_next;
  logic [15:0] time_count, time_count_next;
  logic [6:0]  chosen_angle, chosen_angle_next;
  logic        armed_next;
  logic [15:0] holdoff_left, holdoff_left_next;
  logic        pin_level, pin_level_next;
  logic [15:0] count_sum;

  assign count_sum    = time_count + 16'(cfg.tick_us);
  assign holdoff_busy = (holdoff_left != 16'd0);

  always_comb begin
    duty_time_next    = duty_time;
    time_count_next   = time_count;
    chosen_angle_next = chosen_angle;
    armed_next        = armed;
    holdoff_left_next = holdoff_left;
    pin_level_next    = pin_level;
    case (item.op)
      ltsp_pkg::OP_TICK: begin
        pin_level_next  = (count_sum <= 16'(duty_time));
        time_count_next = (count_sum == cfg.period_us) ? 16'd0 : count_sum;
        if (holdoff_busy) begin
          holdoff_left_next = holdoff_left - 16'd1;
        end
      end
      ltsp_pkg::OP_KEY: begin
        if (!armed) begin
          case (item.key_bits)
            ltsp_pkg::KEY_ANGLE_45: begin
              chosen_angle_next = ltsp_pkg::ANGLE_45;
              armed_next        = 1'b1;
            end
            ltsp_pkg::KEY_ANGLE_90: begin
              chosen_angle_next = ltsp_pkg::ANGLE_90;
              armed_next        = 1'b1;
            end
            ltsp_pkg::KEY_ANGLE_120: begin
              chosen_angle_next = ltsp_pkg::ANGLE_120;
              armed_next        = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ltsp_pkg::OP_ADC: begin
        if (armed && !holdoff_busy) begin
          if (item.adc_value > cfg.high_threshold) begin
            duty_time_next    = ltsp_pkg::pulse_for(chosen_angle);
            holdoff_left_next = cfg.holdoff_ticks;
          end else if (item.adc_value < cfg.low_threshold) begin
            duty_time_next    = ltsp_pkg::DUTY_0;
            holdoff_left_next = cfg.holdoff_ticks;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign result_next.servo_level = pin_level_next;
  assign result_next.duty_us     = duty_time_next;
  assign result_next.is_armed    = armed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_time    <= ltsp_pkg::DUTY_RESET;
      time_count   <= 16'd0;
      chosen_angle <= ltsp_pkg::ANGLE_0;
      armed        <= 1'b0;
      holdoff_left <= 16'd0;
      pin_level    <= 1'b0;
    end else if (advance) begin
      duty_time    <= duty_time_next;
      time_count   <= time_count_next;
      chosen_angle <= chosen_angle_next;
      armed        <= armed_next;
      holdoff_left <= holdoff_left_next;
      pin_level    <= pin_level_next;
    end
  end

endmodule

/* tb/light_triggered_servo_pwm_test.sv */
module light_triggered_servo_pwm_test;
  import ltsp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_ready;
  logic [1:0]           op;
  logic [3:0]           key_bits;
  logic [9:0]           adc_value;
  logic                 result_valid;
  logic                 result_ready;
  logic                 servo_level;
  logic [11:0]          duty_us;
  logic                 is_armed;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  light_triggered_servo_pwm u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .key_bits     (key_bits),
    .adc_value    (adc_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .servo_level  (servo_level),
    .duty_us      (duty_us),
    .is_armed     (is_armed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // shadow registers and servo state
  logic [15:0] period_reg;
  logic [9:0]  tick_reg;
  logic [9:0]  high_thr;
  logic [9:0]  low_thr;
  logic [15:0] holdoff_reg;
  logic [11:0] pulse_width;
  logic [15:0] us_count;
  logic [6:0]  angle_sel;
  logic        armed_flag;
  logic [15:0] holdoff_cnt;
  logic        pin_q;

  result_t pending_results[$];

  int  fail_count;
  int  mismatch_count;
  int  items_sent;
  int  results_seen;
  int  cfg_writes;
  bit  no_idle;
  int  long_hold;

  function automatic logic [11:0] duty_for_angle(input logic [6:0] deg);
    return 12'(500 + (int'(deg) * 200) / 18);
  endfunction

  function automatic result_t step_servo(input logic [1:0] kind, input logic [3:0] key,
                                         input logic [9:0] adc);
    result_t r;
    case (kind)
      OP_TICK: begin
        us_count = us_count + 16'(tick_reg);
        pin_q = (us_count <= 16'(pulse_width));
        if (us_count == period_reg) us_count = '0;
        if (holdoff_cnt != '0) holdoff_cnt = holdoff_cnt - 16'd1;
      end
      OP_KEY: begin
        if (!armed_flag) begin
          case (key)
            KEY_ANGLE_45: begin
              angle_sel = ANGLE_45;
              armed_flag = 1'b1;
            end
            KEY_ANGLE_90: begin
              angle_sel = ANGLE_90;
              armed_flag = 1'b1;
            end
            KEY_ANGLE_120: begin
              angle_sel = ANGLE_120;
              armed_flag = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_ADC: begin
        if (armed_flag && holdoff_cnt == '0) begin
          if (adc > high_thr) begin
            pulse_width = duty_for_angle(angle_sel);
            holdoff_cnt = holdoff_reg;
          end else if (adc < low_thr) begin
            pulse_width = duty_for_angle(ANGLE_0);
            holdoff_cnt = holdoff_reg;
          end
        end
      end
      default: ;
    endcase
    r.servo_level = pin_q;
    r.duty_us     = pulse_width;
    r.is_armed    = armed_flag;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [3:0] key,
                           input logic [9:0] adc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    op         <= kind;
    key_bits   <= key;
    adc_value  <= adc;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(step_servo(kind, key, adc));
    items_sent++;
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PERIOD:   period_reg  = data;
      REG_TICK:     tick_reg    = data[9:0];
      REG_HIGH_THR: high_thr    = data[9:0];
      REG_LOW_THR:  low_thr     = data[9:0];
      REG_HOLDOFF:  holdoff_reg = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every expected beat is back and the pipe is empty
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_item();
    int         pick;
    logic [1:0] kind;
    logic [3:0] key;
    logic [9:0] adc;
    pick = $urandom_range(0, 99);
    key  = 4'($urandom_range(0, 15));
    adc  = 10'($urandom_range(0, 1023));
    if (pick < 50) kind = OP_TICK;
    else if (pick < 85) kind = OP_ADC;
    else if (pick < 95) kind = OP_KEY;
    else kind = OP_UNUSED;
    if (kind == OP_ADC) begin
      case ($urandom_range(0, 7))
        0: adc = high_thr + 10'd1;
        1: adc = high_thr;
        2: adc = low_thr - 10'd1;
        3: adc = low_thr;
        default: ;
      endcase
    end
    send_item(kind, key, adc);
  endtask

  task automatic random_config();
    logic [15:0] tdata;
    logic [15:0] pdata;
    logic [15:0] hdata;
    logic [15:0] ldata;
    logic [15:0] odata;
    case ($urandom_range(0, 9))
      0: tdata = 16'd1;
      1: tdata = 16'd1000;
      2: tdata = 16'd1024;
      3: tdata = 16'($urandom);
      default: tdata = 16'($urandom_range(1, 1000));
    endcase
    case ($urandom_range(0, 7))
      0: pdata = 16'd1;
      1: pdata = 16'hFFFF;
      2: pdata = 16'($urandom);
      default: pdata = 16'(int'(tdata[9:0]) * $urandom_range(1, 30));
    endcase
    case ($urandom_range(0, 5))
      0: hdata = 16'd0;
      1: hdata = 16'd1023;
      2: hdata = 16'($urandom);
      default: hdata = 16'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 5))
      0: ldata = 16'd0;
      1: ldata = 16'd1023;
      2: ldata = 16'($urandom);
      default: ldata = 16'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 9))
      0: odata = 16'd0;
      1: odata = 16'hFFFF;
      2: odata = 16'($urandom);
      default: odata = 16'($urandom_range(0, 6));
    endcase
    write_reg(REG_TICK, tdata);
    write_reg(REG_PERIOD, pdata);
    write_reg(REG_HIGH_THR, hdata);
    write_reg(REG_LOW_THR, ldata);
    write_reg(REG_HOLDOFF, odata);
    if ($urandom_range(0, 2) == 0)
      write_reg(CfgIndexW'(int'(REG_HOLDOFF) + $urandom_range(1, 3)), 16'($urandom));
  endtask

  task automatic test_before_arming();
    send_item(OP_TICK, 4'h0, 10'd0);
    send_item(OP_UNUSED, 4'hF, 10'd1023);
    send_item(OP_ADC, 4'h0, 10'd1023);
    send_item(OP_ADC, 4'hF, 10'd0);
    send_item(OP_KEY, 4'hF, 10'd0);
    send_item(OP_KEY, 4'h0, 10'd1023);
    send_item(OP_KEY, 4'h7, 10'd0);
  endtask

  task automatic test_arming();
    logic [3:0] keys [3];
    int         pick;
    keys[0] = KEY_ANGLE_45;
    keys[1] = KEY_ANGLE_90;
    keys[2] = KEY_ANGLE_120;
    pick = $urandom_range(0, 2);
    send_item(OP_KEY, keys[pick], 10'd0);
    // angle is locked now
    send_item(OP_KEY, keys[(pick + 1) % 3], 10'd0);
  endtask

  task automatic test_thresholds();
    drain();
    write_reg(REG_HOLDOFF, 16'd0);
    send_item(OP_ADC, 4'h0, 10'd1023);
    send_item(OP_ADC, 4'h0, 10'd0);
    send_item(OP_ADC, 4'h0, HIGH_THR_RESET);
    send_item(OP_ADC, 4'h0, LOW_THR_RESET);
    send_item(OP_ADC, 4'h0, HIGH_THR_RESET + 10'd1);
    drain();
    // crossed thresholds, high test wins
    write_reg(REG_HIGH_THR, 16'd0);
    write_reg(REG_LOW_THR, 16'd1023);
    send_item(OP_ADC, 4'h0, 10'd0);
    send_item(OP_ADC, 4'h0, 10'd1);
  endtask

  task automatic test_holdoff();
    drain();
    write_reg(REG_HIGH_THR, 16'(HIGH_THR_RESET));
    write_reg(REG_LOW_THR, 16'(LOW_THR_RESET));
    write_reg(REG_HOLDOFF, 16'd2);
    send_item(OP_ADC, 4'h0, 10'd1023);
    send_item(OP_ADC, 4'h0, 10'd0);
    send_item(OP_TICK, 4'h0, 10'd0);
    send_item(OP_TICK, 4'h0, 10'd0);
    send_item(OP_ADC, 4'h0, 10'd0);
  endtask

  task automatic test_counter();
    drain();
    // masked to zero, counter holds
    write_reg(REG_TICK, 16'd1024);
    write_reg(REG_PERIOD, 16'd1);
    send_item(OP_TICK, 4'h0, 10'd0);
    drain();
    write_reg(REG_TICK, 16'd1);
    send_item(OP_TICK, 4'h0, 10'd0);
    send_item(OP_TICK, 4'h0, 10'd0);
  endtask

  task automatic test_backpressure();
    drain();
    random_config();
    long_hold = 150;
    repeat (40) send_random_item();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 19; phase++) begin
      drain();
      random_config();
      no_idle = (phase % 4 == 3);
      repeat (100) send_random_item();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("light_triggered_servo_pwm verification failed");
    $finish;
  end

  // result side
  initial begin
    int      stall;
    result_t want;
    result_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: level %0b duty %0d armed %0b",
                   servo_level, duty_us, is_armed);
      end else begin
        want = pending_results.pop_front();
        if (servo_level !== want.servo_level || duty_us !== want.duty_us ||
            is_armed !== want.is_armed) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: level %0b/%0b duty %0d/%0d armed %0b/%0b (exp/act)",
                     results_seen, want.servo_level, servo_level, want.duty_us, duty_us,
                     want.is_armed, is_armed);
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    op           = OP_TICK;
    key_bits     = '0;
    adc_value    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_PERIOD;
    cfg_data     = '0;
    no_idle      = 1'b0;
    long_hold    = 0;
    fail_count     = 0;
    mismatch_count = 0;
    items_sent     = 0;
    results_seen   = 0;
    cfg_writes     = 0;
    period_reg  = PERIOD_RESET;
    tick_reg    = TICK_RESET;
    high_thr    = HIGH_THR_RESET;
    low_thr     = LOW_THR_RESET;
    holdoff_reg = HOLDOFF_RESET;
    pulse_width = DUTY_RESET;
    us_count    = '0;
    angle_sel   = ANGLE_0;
    armed_flag  = 1'b0;
    holdoff_cnt = '0;
    pin_q       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_before_arming();
    test_arming();
    test_thresholds();
    test_holdoff();
    test_counter();
    test_backpressure();
    test_random();

    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    $display("sent %0d items, checked %0d result beats, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("angle locked at %0d degrees, %0d mismatches", angle_sel, mismatch_count);
    if (fail_count == 0 && mismatch_count == 0) begin
      $display("light_triggered_servo_pwm verification clean");
    end else begin
      $display("light_triggered_servo_pwm verification failed");
    end
    $finish;
  end

endmodule
